### src/dssm_pkg.sv
// Shared types and constants for the dual stack shared memory block.
package dssm_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 9;

  // Operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                operation;
    logic                      stack_select;
    logic signed [VALUE_W-1:0] push_value;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        low_count;
    logic [COUNT_W-1:0]        high_count;
    logic                      low_empty;
    logic                      high_empty;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

### src/dssm_ctrl.sv
// Controller state machine: sequences capture, execute and respond for one request.
module dssm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output dssm_pkg::dp_cmd_t cmd
);
  import dssm_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    done        = 1'b0;
    busy        = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/dssm_datapath.sv
// Datapath: shared stack memory, fill counters, capacity register and result register.
module dssm_datapath #(
  parameter int DEPTH      = 256,
  parameter int WORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dssm_pkg::dp_cmd_t               cmd,
  input  dssm_pkg::request_t              request,
  input  logic                            capacity_we,
  input  logic [dssm_pkg::COUNT_W-1:0]    capacity,
  output dssm_pkg::result_t               result
);
  import dssm_pkg::*;

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_LIMIT = (DEPTH > (2**COUNT_W - 1)) ? (2**COUNT_W - 1) : DEPTH;
  localparam int CAP_RESET = (DEPTH > 256) ? 256 : DEPTH;
  localparam logic [COUNT_W-1:0] CAP_MAX  = COUNT_W'(CAP_LIMIT);
  localparam logic [COUNT_W-1:0] CAP_INIT = COUNT_W'(CAP_RESET);

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata;

  request_t           req;
  logic [COUNT_W-1:0] cap;
  logic [COUNT_W-1:0] low_fill;
  logic [COUNT_W-1:0] high_fill;
  logic [COUNT_W-1:0] low_fill_next;
  logic [COUNT_W-1:0] high_fill_next;
  result_t            res;
  logic               top_from_mem;

  logic [COUNT_W-1:0] fill_sel;
  logic [COUNT_W:0]   fill_sum;
  logic               full;
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [COUNT_W-1:0] slot;
  logic signed [VALUE_W-1:0] top_next;
  logic [1:0]         status_next;
  logic signed [63:0] rdata_ext;

  // Latch the request on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
  end

  // Evaluate the request against the current fills
  always_comb begin
    fill_sel       = req.stack_select ? high_fill : low_fill;
    fill_sum       = {1'b0, low_fill} + {1'b0, high_fill};
    full           = fill_sum >= {1'b0, cap};
    low_fill_next  = low_fill;
    high_fill_next = high_fill;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    slot           = low_fill;
    top_next       = '0;
    status_next    = STATUS_DONE;
    unique case (req.operation)
      OP_PUSH: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else if (req.stack_select) begin
          high_fill_next = high_fill + COUNT_W'(1);
          slot           = cap - high_fill_next;
          wr_en          = 1'b1;
        end else begin
          slot          = low_fill;
          low_fill_next = low_fill + COUNT_W'(1);
          wr_en         = 1'b1;
        end
      end
      OP_POP: begin
        if (fill_sel == '0) begin
          status_next = STATUS_EMPTY;
        end else if (req.stack_select) begin
          high_fill_next = high_fill - COUNT_W'(1);
        end else begin
          low_fill_next = low_fill - COUNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (fill_sel == '0) begin
          status_next = STATUS_EMPTY;
          top_next    = -VALUE_W'(1);
        end else begin
          rd_en = 1'b1;
          slot  = req.stack_select ? (cap - high_fill) : (low_fill - COUNT_W'(1));
        end
      end
      default: begin
      end
    endcase
    waddr = AW'(slot);
    raddr = AW'(slot);
  end

  // Capacity and fill counters; a capacity write empties both stacks
  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_INIT;
      low_fill  <= '0;
      high_fill <= '0;
    end else if (capacity_we) begin
      cap       <= (capacity > CAP_MAX) ? CAP_MAX : capacity;
      low_fill  <= '0;
      high_fill <= '0;
    end else if (cmd.exec) begin
      low_fill  <= low_fill_next;
      high_fill <= high_fill_next;
    end
  end

  // Stack memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[waddr] <= WORD_WIDTH'($unsigned(req.push_value));
    end
    if (cmd.exec && rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res.top_value  <= top_next;
      res.status     <= status_next;
      res.low_count  <= low_fill_next;
      res.high_count <= high_fill_next;
      res.low_empty  <= (low_fill_next == '0);
      res.high_empty <= (high_fill_next == '0);
      top_from_mem   <= rd_en;
    end
  end

  // Stored word is sign-extended from its width
  assign rdata_ext = 64'(signed'(rdata));

  always_comb begin
    result = res;
    if (top_from_mem) begin
      result.top_value = rdata_ext[VALUE_W-1:0];
    end
  end

endmodule

### src/dual_stack_shared_memory.sv
// Top level of the dual stack shared memory: controller plus datapath.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-----------------------------------
//  request  | start, busy, request           | transfer when start && !busy
//  result   | done, result                   | done high one cycle, no back-pressure
//  config   | capacity_we, capacity          | written on any edge with capacity_we
//
// Each request passes through accept, execute (fill update, memory write or
// read) and respond; busy stays high for the execute and respond cycles.
// Reset clears both fills and sets capacity to 256 (clipped to DEPTH); memory
// contents are not cleared. Results cannot be stalled by the receiver.
module dual_stack_shared_memory #(
  parameter int DEPTH      = 256,
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  dssm_pkg::request_t           request,
  output logic                         done,
  output dssm_pkg::result_t            result,
  input  logic                         capacity_we,
  input  logic [dssm_pkg::COUNT_W-1:0] capacity
);
  import dssm_pkg::*;

  dp_cmd_t cmd;

  dssm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  dssm_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .request     (request),
    .capacity_we (capacity_we),
    .capacity    (capacity),
    .result      (result)
  );

endmodule

### bench/dual_stack_shared_memory_test.sv
// Self-checking testbench for the dual stack shared memory block.
module dual_stack_shared_memory_test;
  import dssm_pkg::*;

  localparam int DEPTH = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 100000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One line of the directed stimulus table
  typedef struct {
    bit                 is_cfg;
    logic [COUNT_W-1:0] cap;
    request_t           req;
    bit                 typed;
    result_t            res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  request_t           request = '0;
  logic               done;
  result_t            result;
  logic               capacity_we = 1'b0;
  logic [COUNT_W-1:0] capacity = '0;

  // Shadow copy of the block's state
  logic signed [VALUE_W-1:0] stack_mem [0:DEPTH-1];
  int                        model_low_fill = 0;
  int                        model_high_fill = 0;
  int                        model_capacity = 256;

  result_t   results_due[$];
  stim_row_t directed_rows[$];
  bit        use_typed = 1'b0;
  result_t   typed_result = '0;
  bit        idle_enabled = 1'b1;
  int        transfer_count = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  dual_stack_shared_memory DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .capacity_we(capacity_we),
    .capacity   (capacity)
  );

  always #5 clk = ~clk;

  // Run-length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Expected result of one request; updates the shadow state
  function automatic result_t predict_stack_op(request_t r);
    result_t res;
    int      room;
    int      fill;
    room = (model_capacity > DEPTH) ? DEPTH : model_capacity;
    fill = r.stack_select ? model_high_fill : model_low_fill;
    res = '0;
    res.status = STATUS_DONE;
    case (r.operation)
      OP_PUSH: begin
        if (model_low_fill + model_high_fill >= room) begin
          res.status = STATUS_FULL;
        end else if (r.stack_select) begin
          model_high_fill++;
          stack_mem[ADDR_W'(room - model_high_fill)] = r.push_value;
        end else begin
          stack_mem[ADDR_W'(model_low_fill)] = r.push_value;
          model_low_fill++;
        end
      end
      OP_POP: begin
        if (fill == 0) begin
          res.status = STATUS_EMPTY;
        end else if (r.stack_select) begin
          model_high_fill--;
        end else begin
          model_low_fill--;
        end
      end
      OP_PEEK: begin
        if (fill == 0) begin
          res.status = STATUS_EMPTY;
          res.top_value = -1;
        end else if (r.stack_select) begin
          res.top_value = stack_mem[ADDR_W'(room - model_high_fill)];
        end else begin
          res.top_value = stack_mem[ADDR_W'(model_low_fill - 1)];
        end
      end
      default: ; // unused code leaves everything alone
    endcase
    res.low_count = model_low_fill[COUNT_W-1:0];
    res.high_count = model_high_fill[COUNT_W-1:0];
    res.low_empty = (model_low_fill == 0);
    res.high_empty = (model_high_fill == 0);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Monitor: predict on each request transfer, check each result
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (capacity_we) begin
        model_capacity = int'(capacity);
        model_low_fill = 0;
        model_high_fill = 0;
      end
      if (start && !busy) begin
        want = predict_stack_op(request);
        if (use_typed) want = typed_result;
        results_due.push_back(want);
        transfer_count++;
      end
      if (done) begin
        if (results_due.size() == 0) begin
          check_field("result with none pending", 32'h0, 32'hFFFF_FFFF);
        end else begin
          want = results_due.pop_front();
          check_field("top_value", want.top_value, result.top_value);
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("low_count", 32'(want.low_count), 32'(result.low_count));
          check_field("high_count", 32'(want.high_count), 32'(result.high_count));
          check_field("low_empty", 32'(want.low_empty), 32'(result.low_empty));
          check_field("high_empty", 32'(want.high_empty), 32'(result.high_empty));
        end
      end
    end
  end

  // Drive one request; returns at the falling edge after its transfer
  task automatic issue_request(request_t r, bit typed, result_t res);
    int prior;
    while (idle_enabled && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    request <= r;
    use_typed = typed;
    typed_result = res;
    prior = transfer_count;
    do @(negedge clk); while (transfer_count == prior);
  endtask

  // Hold off until every pending result has come back
  task automatic wait_for_idle();
    start <= 1'b0;
    while (results_due.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_capacity(logic [COUNT_W-1:0] value);
    capacity_we <= 1'b1;
    capacity <= value;
    @(negedge clk);
    capacity_we <= 1'b0;
  endtask

  function automatic request_t make_req(logic [1:0] op, logic sel, logic [31:0] value);
    request_t r;
    r.operation = op;
    r.stack_select = sel;
    r.push_value = value;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, logic sel, logic [31:0] value);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cap = '0;
    row.req = make_req(op, sel, value);
    row.typed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic [1:0] op, logic sel, logic [31:0] value,
                                    logic [31:0] top, logic [1:0] status, int lc, int hc);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cap = '0;
    row.req = make_req(op, sel, value);
    row.typed = 1'b1;
    row.res = result_t'{top, status, lc[COUNT_W-1:0], hc[COUNT_W-1:0], lc == 0, hc == 0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [COUNT_W-1:0] value);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.cap = value;
    row.req = '0;
    row.typed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic request_t random_request(int push_pct);
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      r.operation = OP_UNUSED;
    else if (pick < 3 + push_pct)
      r.operation = OP_PUSH;
    else
      r.operation = $urandom_range(0, 1) ? OP_POP : OP_PEEK;
    r.stack_select = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 19))
      0: r.push_value = 32'h8000_0000;
      1: r.push_value = 32'h7FFF_FFFF;
      2: r.push_value = 32'h0;
      3: r.push_value = 32'hFFFF_FFFF;
      default: r.push_value = $urandom;
    endcase
    return r;
  endfunction

  // Stimulus
  initial begin
    int cap_value;
    int items;
    int push_pct;

    // Directed table: empty stacks after reset, extremes, full and empty refusals
    add_typed(OP_PEEK, 1'b0, 32'h0, 32'hFFFF_FFFF, STATUS_EMPTY, 0, 0);
    add_typed(OP_POP, 1'b1, 32'h0, 32'h0, STATUS_EMPTY, 0, 0);
    add_typed(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'h0, STATUS_DONE, 0, 0);
    add_typed(OP_PUSH, 1'b0, 32'h7FFF_FFFF, 32'h0, STATUS_DONE, 1, 0);
    add_typed(OP_PUSH, 1'b1, 32'h8000_0000, 32'h0, STATUS_DONE, 1, 1);
    add_typed(OP_PEEK, 1'b0, 32'h0, 32'h7FFF_FFFF, STATUS_DONE, 1, 1);
    add_row(OP_PEEK, 1'b1, 32'h0);
    add_row(OP_PUSH, 1'b0, 32'hFFFF_FFFF);
    add_row(OP_PUSH, 1'b1, 32'h0);
    add_row(OP_PEEK, 1'b0, 32'h0);
    add_row(OP_POP, 1'b0, 32'h0);
    add_row(OP_PEEK, 1'b0, 32'h0);
    add_row(OP_POP, 1'b1, 32'h0);
    add_row(OP_PEEK, 1'b1, 32'h0);
    // single shared entry
    add_cfg(9'd1);
    add_typed(OP_PUSH, 1'b1, 32'h1234_5678, 32'h0, STATUS_DONE, 0, 1);
    add_typed(OP_PUSH, 1'b0, 32'h0, 32'h0, STATUS_FULL, 0, 1);
    add_row(OP_PEEK, 1'b1, 32'h0);
    add_typed(OP_POP, 1'b1, 32'h0, 32'h0, STATUS_DONE, 0, 0);
    add_typed(OP_POP, 1'b1, 32'h0, 32'h0, STATUS_EMPTY, 0, 0);
    // no room at all
    add_cfg(9'd0);
    add_typed(OP_PUSH, 1'b0, 32'h2A, 32'h0, STATUS_FULL, 0, 0);
    add_typed(OP_PEEK, 1'b1, 32'h0, 32'hFFFF_FFFF, STATUS_EMPTY, 0, 0);
    // capacity above the memory size saturates
    add_cfg(9'd511);
    add_row(OP_PUSH, 1'b1, 32'hDEAD_BEEF);
    add_row(OP_PEEK, 1'b1, 32'h0);
    // two entries, both stacks meet in the middle
    add_cfg(9'd2);
    add_row(OP_PUSH, 1'b0, 32'h5555_5555);
    add_row(OP_PUSH, 1'b1, 32'hAAAA_AAAA);
    add_typed(OP_PUSH, 1'b0, 32'h1, 32'h0, STATUS_FULL, 1, 1);
    add_row(OP_PEEK, 1'b0, 32'h0);
    add_row(OP_PEEK, 1'b1, 32'h0);

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_for_idle();
        write_capacity(directed_rows[i].cap);
      end else begin
        issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
      end
    end

    // Random phases, one capacity setting each
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin cap_value = 256; items = 300; push_pct = 95; end
        1: begin cap_value = 1; items = 60; push_pct = 50; end
        2: begin cap_value = 2; items = 60; push_pct = 50; end
        3: begin cap_value = 3; items = 60; push_pct = 45; end
        4: begin cap_value = $urandom_range(4, 40); items = 60; push_pct = 55; end
        5: begin cap_value = 511; items = 60; push_pct = 60; end
        6: begin cap_value = 0; items = 30; push_pct = 50; end
        7: begin cap_value = 300; items = 60; push_pct = 45; end
        8: begin cap_value = $urandom_range(1, 256); items = 80; push_pct = 60; end
        default: begin cap_value = 256; items = 40; push_pct = 35; end
      endcase
      wait_for_idle();
      write_capacity(cap_value[COUNT_W-1:0]);
      for (int n = 0; n < items; n++) begin
        // back-to-back stretch at the start of the deep phase
        idle_enabled = !(phase == 0 && n < 150);
        if (phase == 0 && n == 160) wait_for_idle();
        issue_request(random_request(push_pct), 1'b0, '0);
      end
    end
    idle_enabled = 1'b1;

    wait_for_idle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### dual_stack_shared_memory.f
src/dssm_pkg.sv
src/dssm_ctrl.sv
src/dssm_datapath.sv
src/dual_stack_shared_memory.sv
bench/dual_stack_shared_memory_test.sv
